/* hdl/pcml_pkg.sv */
package pcml_pkg;

  // Color selection written through the map_mode register
  typedef enum logic [1:0] {
    MODE_JET   = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_FADE  = 2'd2
  } mode_e;

  // Result status code
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ZERO_COUNT = 2'd1,
    STAT_SATURATED  = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAP_MODE   = 2'd0,
    REG_BASE_RED   = 2'd1,
    REG_BASE_GREEN = 2'd2,
    REG_BASE_BLUE  = 2'd3
  } reg_e;

  // Configuration seen by the shading stages
  typedef struct packed {
    mode_e      map_mode;
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
  } cfg_t;

  // Color lanes: red, green, blue
  localparam int NUM_LANES = 3;
  localparam int CHAN_W    = 8;

  // Jet ramp offsets in units of the table size, per lane
  localparam int JET_LO_OFF [NUM_LANES] = '{-3, -1, 1};
  localparam int JET_HI_OFF [NUM_LANES] = '{9, 7, 5};

endpackage

/* hdl/pcml_div_cell.sv */
module pcml_div_cell #(
  parameter int LANES = 1,
  parameter int RW    = 16,
  parameter int QW    = 9,
  parameter int SW    = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [LANES-1:0][RW-1:0]       rem_i,
  input  logic [LANES-1:0][RW-1:0]       div_i,
  input  logic [LANES-1:0]               bit_i,
  input  logic [LANES-1:0][QW-1:0]       quo_i,
  input  logic [SW-1:0]                  side_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic [LANES-1:0][RW-1:0]       rem_o,
  output logic [LANES-1:0][RW-1:0]       div_o,
  output logic [LANES-1:0][QW-1:0]       quo_o,
  output logic [SW-1:0]                  side_o
);

  logic                     valid_q;
  logic                     advance;
  logic [LANES-1:0][RW-1:0] rem_d, rem_q;
  logic [LANES-1:0][RW-1:0] div_q;
  logic [LANES-1:0][QW-1:0] quo_d, quo_q;
  logic [SW-1:0]            side_q;

  // Advance when empty or when the next cell takes our request
  assign advance = !valid_q || !stall_i;
  assign stall_o = !advance;

  // One restoring division step per lane: shift in a dividend bit, try subtract
  always_comb begin
    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;
    rem_d = '0;
    quo_d = '0;
    for (int l = 0; l < LANES; l++) begin
      trial    = {rem_i[l], bit_i[l]};
      diff     = trial - {1'b0, div_i[l]};
      ge       = trial >= {1'b0, div_i[l]};
      rem_d[l] = ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_d[l] = {quo_i[l][QW-2:0], ge};
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  // Load the payload on an accepted request
  always_ff @(posedge clk_i) begin
    if (valid_i && advance) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

/* hdl/pcml_shade.sv */
module pcml_shade #(
  parameter int TABLE_ENTRIES = 256,
  localparam int QW  = $clog2(TABLE_ENTRIES + 1),
  localparam int RWC = $clog2(2 * TABLE_ENTRIES + 1),
  localparam int XW  = RWC + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcml_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [15:0]          idx_i,
  input  logic [QW-1:0]        quo_i,
  input  logic                 zero_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [2:0][7:0]      color_o,
  output logic [1:0]           status_o
);

  import pcml_pkg::*;

  localparam int EW  = $clog2(TABLE_ENTRIES);
  localparam int PW  = 16 + QW;
  localparam int JW  = $clog2(9 * TABLE_ENTRIES + 1) + 1;
  localparam int SR  = XW + RWC;
  localparam int MW  = SR - $clog2(TABLE_ENTRIES) + 2;
  localparam int PRW = XW + MW;
  localparam logic [EW-1:0]        LAST_ENTRY = EW'(TABLE_ENTRIES - 1);
  localparam logic [RWC-1:0]       DIV_JET    = RWC'(2 * TABLE_ENTRIES);
  localparam logic signed [JW-1:0] TWO_T      = JW'(2 * TABLE_ENTRIES);
  // Rounded-up reciprocals, exact for every numerator below 2**XW
  localparam logic [MW-1:0] RCP_JET  =
    MW'(((64'd1 << SR) + 64'(2 * TABLE_ENTRIES) - 64'd1) / 64'(2 * TABLE_ENTRIES));
  localparam logic [MW-1:0] RCP_FADE =
    MW'(((64'd1 << SR) + 64'(TABLE_ENTRIES - 1) - 64'd1) / 64'(TABLE_ENTRIES - 1));

  // Entry stage
  logic          a_valid_q;
  logic          a_advance;
  logic [PW-1:0] prod;
  logic [EW-1:0] a_entry_d, a_entry_q;
  status_e       a_status_d, a_status_q;

  // Numerator stage
  logic                 b_valid_q;
  logic                 b_advance;
  logic [2:0][XW-1:0]   b_x_d, b_x_q;
  logic                 b_fade_d, b_fade_q;
  logic [2:0][7:0]      b_add_d, b_add_q;
  status_e              b_status_q;

  // Scaling stage
  logic                 c_valid_q;
  logic                 c_advance;
  logic [2:0][7:0]      c_color_d, c_color_q;
  status_e              c_status_q;

  assign c_advance = !c_valid_q || !stall_i;
  assign b_advance = !b_valid_q || c_advance;
  assign a_advance = !a_valid_q || b_advance;
  assign stall_o   = !a_advance;

  // Scale the index by the quotient and saturate into the table; a zero count gives entry 0
  always_comb begin
    prod = PW'(idx_i) * PW'(quo_i);
    if (zero_i) begin
      a_entry_d  = '0;
      a_status_d = STAT_ZERO_COUNT;
    end else if (prod > PW'(TABLE_ENTRIES - 1)) begin
      a_entry_d  = LAST_ENTRY;
      a_status_d = STAT_SATURATED;
    end else begin
      a_entry_d  = prod[EW-1:0];
      a_status_d = STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_advance) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_advance) begin
      a_entry_q  <= a_entry_d;
      a_status_q <= a_status_d;
    end
  end

  // Build numerator, divisor select and addend for each lane
  always_comb begin
    logic [7:0]           base [NUM_LANES];
    logic [7:0]           diff;
    logic signed [JW-1:0] e8;
    logic signed [JW-1:0] ja;
    logic signed [JW-1:0] jb;
    logic signed [JW-1:0] jm;
    logic [RWC-1:0]       m;
    logic [XW-1:0]        xj;
    logic [XW-1:0]        xf;
    base[0]  = cfg_i.base_red;
    base[1]  = cfg_i.base_green;
    base[2]  = cfg_i.base_blue;
    e8       = $signed(JW'({a_entry_q, 3'b000}));
    b_fade_d = (cfg_i.map_mode == MODE_FADE);
    b_x_d    = '0;
    b_add_d  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      // Jet ramp: clamp the tent, then scale by 255
      ja = e8 + JW'(JET_LO_OFF[l] * TABLE_ENTRIES);
      jb = JW'(JET_HI_OFF[l] * TABLE_ENTRIES) - e8;
      jm = (ja < jb) ? ja : jb;
      if (jm < 0) begin
        m = '0;
      end else if (jm > TWO_T) begin
        m = DIV_JET;
      end else begin
        m = jm[RWC-1:0];
      end
      xj = XW'({m, 8'h00}) - XW'(m);
      // Fade: distance to white times entry
      diff = 8'hFF - base[l];
      xf   = XW'(diff) * XW'(a_entry_q);
      case (cfg_i.map_mode)
        MODE_FIXED: begin
          b_x_d[l]   = '0;
          b_add_d[l] = base[l];
        end
        MODE_FADE: begin
          b_x_d[l]   = xf;
          b_add_d[l] = base[l];
        end
        default: begin
          b_x_d[l]   = xj;
          b_add_d[l] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_advance) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_advance) begin
      b_x_q      <= b_x_d;
      b_fade_q   <= b_fade_d;
      b_add_q    <= b_add_d;
      b_status_q <= a_status_q;
    end
  end

  // Divide by the ramp length through a reciprocal multiply, then add the base
  always_comb begin
    logic [MW-1:0]  rcp;
    logic [PRW-1:0] scaled;
    rcp       = b_fade_q ? RCP_FADE : RCP_JET;
    c_color_d = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      scaled       = PRW'(b_x_q[l]) * PRW'(rcp);
      c_color_d[l] = b_add_q[l] + scaled[SR +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_advance) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_advance) begin
      c_color_q  <= c_color_d;
      c_status_q <= b_status_q;
    end
  end

  assign valid_o  = c_valid_q;
  assign color_o  = c_color_q;
  assign status_o = c_status_q;

endmodule

/* hdl/pseudo_color_map_lookup.sv */
// Pseudo-color map lookup: turns an element index and element count into an
// RGB color (jet gradient, fixed base color, or fade from base to white).
//
// Request channel: valid_i / stall_o with element_index_i, element_count_i.
// Result channel:  valid_o / stall_i with red_o, green_o, blue_o, status_o.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i; the user
// must do so only while no request is in flight; the block does not enforce it.
//
// One request is taken per cycle while stall_o is low. Each result passes
// through the cell chain: one restoring divider cell per quotient bit of
// TABLE_ENTRIES / count, then three shading stages (entry, numerator,
// reciprocal scaling).
//
// A stalled result holds in the last shading stage; requests keep entering
// while empty slots remain in the chain, and stall_o rises only when all are
// full. Reset empties the pipeline and zeroes the config registers (jet mode).
module pseudo_color_map_lookup #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] element_index_i,
  input  logic [15:0] element_count_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [1:0]  status_o
);

  import pcml_pkg::*;

  localparam int QW   = $clog2(TABLE_ENTRIES + 1);
  localparam int SW_F = 17;
  localparam logic [QW-1:0] T_BITS = QW'(TABLE_ENTRIES);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{map_mode: MODE_JET, base_red: '0, base_green: '0, base_blue: '0};
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_MAP_MODE:   cfg_q.map_mode   <= mode_e'(cfg_data_i[1:0]);
        REG_BASE_RED:   cfg_q.base_red   <= cfg_data_i;
        REG_BASE_GREEN: cfg_q.base_green <= cfg_data_i;
        REG_BASE_BLUE:  cfg_q.base_blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Quotient chain: TABLE_ENTRIES / count, one bit per cell
  logic [QW:0]                f_valid;
  logic [QW:0]                f_stall;
  logic [QW:0][0:0][15:0]     f_rem;
  logic [QW:0][0:0][15:0]     f_div;
  logic [QW:0][0:0][QW-1:0]   f_quo;
  logic [QW:0][SW_F-1:0]      f_side;

  assign f_valid[0] = valid_i;
  assign stall_o    = f_stall[0];
  assign f_rem[0]   = '0;
  assign f_div[0]   = element_count_i;
  assign f_quo[0]   = '0;
  assign f_side[0]  = {(element_count_i == 16'd0), element_index_i};

  for (genvar k = 0; k < QW; k++) begin : g_quo_cell
    pcml_div_cell #(
      .LANES(1),
      .RW   (16),
      .QW   (QW),
      .SW   (SW_F)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(f_valid[k]),
      .stall_o(f_stall[k]),
      .rem_i  (f_rem[k]),
      .div_i  (f_div[k]),
      .bit_i  (T_BITS[QW-1-k]),
      .quo_i  (f_quo[k]),
      .side_i (f_side[k]),
      .valid_o(f_valid[k+1]),
      .stall_i(f_stall[k+1]),
      .rem_o  (f_rem[k+1]),
      .div_o  (f_div[k+1]),
      .quo_o  (f_quo[k+1]),
      .side_o (f_side[k+1])
    );
  end

  // Entry, numerator and scaling stages
  logic [2:0][7:0] s_color;

  pcml_shade #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (f_valid[QW]),
    .stall_o (f_stall[QW]),
    .idx_i   (f_side[QW][15:0]),
    .quo_i   (f_quo[QW][0]),
    .zero_i  (f_side[QW][16]),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .color_o (s_color),
    .status_o(status_o)
  );

  // Result lanes: red, green, blue
  assign red_o   = s_color[0];
  assign green_o = s_color[1];
  assign blue_o  = s_color[2];

endmodule
